// ===== rtl/pfa_pkg.sv =====
// Shared types and codes for the partition fit allocator.
package pfa_pkg;

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STRATEGY   = 1'b0;
    localparam logic CFG_PART_COUNT = 1'b1;

    // Widths of the configuration port and the fixed payload ports.
    localparam int CFG_DATA_W = 5;
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;

    // Placement rule.
    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2
    } mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    // Control for the shared scan unit.
    typedef struct packed {
        logic  clear;
        logic  valid;
        mode_t mode;
    } scan_ctrl_t;

    // Map the strategy register onto a placement rule; the unused code acts as first fit.
    function automatic mode_t decode_mode(input logic [1:0] code);
        mode_t m;
        begin
            case (code)
                2'd1:    m = MODE_BEST;
                2'd2:    m = MODE_WORST;
                default: m = MODE_FIRST;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/pfa_slot_mem.sv =====
// Free-size table: one write port and one registered read port.
module pfa_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pfa_scan_unit.sv =====
// Shared compare unit that tracks the chosen slot while the table is scanned.
module pfa_scan_unit
    import pfa_pkg::*;
#(
    parameter int IDX_W  = 4,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] amount,
    input  logic [DATA_W-1:0] data,
    input  logic [IDX_W-1:0]  idx,
    output logic              hit,
    output logic [IDX_W-1:0]  pick,
    output logic [DATA_W-1:0] best
);

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  pick_reg;
    logic [IDX_W-1:0]  pick_next;
    logic [DATA_W-1:0] best_reg;
    logic [DATA_W-1:0] best_next;
    logic              fits;
    logic              take;

    // Decide whether the slot now presented replaces the current choice.
    always_comb
    begin
        fits = (data >= amount);
        case (ctrl.mode)
            MODE_BEST:  take = fits && (!found_reg || (data < best_reg));
            MODE_WORST: take = !found_reg || (data > best_reg);
            default:    take = fits && !found_reg;
        endcase

        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.valid && take)
        begin
            found_next = 1'b1;
            pick_next  = idx;
            best_next  = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    // Worst fit keeps the largest slot and checks the fit only at the end.
    assign hit  = found_reg && (best_reg >= amount);
    assign pick = pick_reg;
    assign best = best_reg;

endmodule

// ===== rtl/partition_fit_allocator_top.sv =====
// Top level of the partition fit allocator: sequencer, registers and result port.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  command  | start, busy           | op, slot, amount
//  result   | done (one-cycle)      | granted, chosen_slot, free_before
//  config   | cfg_we                | cfg_index, cfg_wdata
//
// A load is taken while idle and keeps busy low. With N slots in use (partition_count
// limited to MAX_SLOTS), an allocate keeps busy high through the scan, drain and write-back
// states: one table read per slot through the single read port, a drain state for the read
// latency and one write-back state. With no slots in use only the write-back state remains.
// done pulses in the cycle after the write-back state.
// Reset clears the configuration registers, the sequencer and done; the table and result payload are not cleared.
// The receiver cannot stall the result; busy is high during an allocate.
module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int MAX_SLOTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [AMOUNT_W-1:0]   amount,
    output logic                  done,
    output logic                  granted,
    output logic [SLOT_W-1:0]     chosen_slot,
    output logic [AMOUNT_W-1:0]   free_before
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [1:0]           strategy_reg;
    logic [4:0]           part_count_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [SIZE_BITS-1:0] amt_reg;
    logic [SIZE_BITS-1:0] amt_next;
    logic                 cmp_valid_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 done_reg;
    logic                 done_next;
    logic                 granted_reg;
    logic                 granted_next;
    logic [SLOT_W-1:0]    chosen_reg;
    logic [SLOT_W-1:0]    chosen_next;
    logic [AMOUNT_W-1:0]  free_reg;
    logic [AMOUNT_W-1:0]  free_next;

    logic                 accept;
    logic [31:0]          amount_wide;
    logic [31:0]          slot_wide;
    logic [CNT_W-1:0]     count_eff;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;
    scan_ctrl_t           scan_ctrl;
    logic                 scan_hit;
    logic [IDX_W-1:0]     scan_pick;
    logic [SIZE_BITS-1:0] scan_best;
    logic [31:0]          pick_wide;
    logic [31:0]          best_wide;

    assign accept      = start && !busy;
    assign busy        = (state_reg != ST_IDLE);
    assign amount_wide = {16'd0, amount};
    assign slot_wide   = {28'd0, slot};
    assign pick_wide   = 32'(scan_pick);
    assign best_wide   = 32'(scan_best);

    // Slots in use, limited to the table depth.
    assign count_eff = (32'(part_count_reg) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                              : CNT_W'(part_count_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg   <= 2'd0;
            part_count_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRATEGY:   strategy_reg   <= cfg_wdata[1:0];
                CFG_PART_COUNT: part_count_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Sequencer: next state, table accesses and result.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        amt_next     = amt_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        chosen_next  = chosen_reg;
        free_next    = free_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot_wide[IDX_W-1:0];
        mem_wdata    = amount_wide[SIZE_BITS-1:0];
        mem_raddr    = idx_reg[IDX_W-1:0];
        scan_ctrl.clear = 1'b0;
        scan_ctrl.valid = cmp_valid_reg;
        scan_ctrl.mode  = decode_mode(strategy_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LOAD)
                    begin
                        mem_we = (slot_wide < 32'(MAX_SLOTS));
                    end
                    else
                    begin
                        amt_next        = amount_wide[SIZE_BITS-1:0];
                        count_next      = count_eff;
                        idx_next        = '0;
                        scan_ctrl.clear = 1'b1;
                        state_next      = (count_eff == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_next == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we       = scan_hit;
                mem_waddr    = scan_pick;
                mem_wdata    = scan_best - amt_reg;
                done_next    = 1'b1;
                granted_next = scan_hit;
                chosen_next  = scan_hit ? pick_wide[SLOT_W-1:0] : '0;
                free_next    = scan_hit ? best_wide[AMOUNT_W-1:0] : '0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= (state_reg == ST_SCAN);
            done_reg      <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        idx_reg     <= idx_next;
        amt_reg     <= amt_next;
        cmp_idx_reg <= idx_reg[IDX_W-1:0];
        granted_reg <= granted_next;
        chosen_reg  <= chosen_next;
        free_reg    <= free_next;
    end

    pfa_slot_mem #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (SIZE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_scan_unit #(
        .IDX_W  (IDX_W),
        .DATA_W (SIZE_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .amount (amt_reg),
        .data   (mem_rdata),
        .idx    (cmp_idx_reg),
        .hit    (scan_hit),
        .pick   (scan_pick),
        .best   (scan_best)
    );

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign chosen_slot = chosen_reg;
    assign free_before = free_reg;

`ifndef SYNTHESIS
    // A result transfer never repeats in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // An accepted allocate makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_ALLOC) |=> busy)
        else $error("allocate accepted without going busy");

    // A refused request reports zero slot and zero size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (chosen_slot == '0 && free_before == '0))
        else $error("refused request carries nonzero payload");

    // The scan only runs with at least one slot in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan started with no slots in use");

    // The result leaves with the block returning to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while still busy");
`endif

endmodule
